/* hdl/wfs_pkg.sv */
// Shared types, register indexes and drive codes of the wire follow steering controller.
package wfs_pkg;

  localparam int unsigned MAG_W  = 13;
  localparam int unsigned GAIN_W = 10;
  localparam int unsigned PROD_W = MAG_W + GAIN_W;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned ELAP_W = 16;
  localparam int unsigned CORR_W = 16;

  // reciprocal of 100 in Q29, exact for every product up to 4096 * 1023
  localparam int unsigned RECIP_W     = 23;
  localparam int unsigned RECIP_SHIFT = 29;
  localparam logic [RECIP_W-1:0] RECIP_100 = 23'd5368710;

  localparam logic [7:0] SPEED_MAX   = 8'd255;
  localparam logic [7:0] ROT_OFFSET  = 8'd35;
  localparam logic [CORR_W-1:0] ROT_SAT = 16'd290;

  localparam logic [2:0] REG_P_GAIN     = 3'd0;
  localparam logic [2:0] REG_SIDE_LIMIT = 3'd1;
  localparam logic [2:0] REG_SIDE_SHORT = 3'd2;
  localparam logic [2:0] REG_CLOCKWISE  = 3'd3;
  localparam logic [2:0] REG_ZONE_MODE  = 3'd4;
  localparam logic [2:0] REG_ZONE_ONE   = 3'd5;
  localparam logic [2:0] REG_ZONE_TWO   = 3'd6;

  localparam logic [2:0] MODE_FWD        = 3'd0;
  localparam logic [2:0] MODE_ROT_RIGHT  = 3'd1;
  localparam logic [2:0] MODE_ROT_LEFT   = 3'd2;
  localparam logic [2:0] MODE_ONLY_RIGHT = 3'd3;
  localparam logic [2:0] MODE_BACK_SLOW  = 3'd4;
  localparam logic [2:0] MODE_STOP       = 3'd5;

  localparam logic [2:0] NS_STAY       = 3'd0;
  localparam logic [2:0] NS_FIND_BACK  = 3'd1;
  localparam logic [2:0] NS_RANDOM_ROT = 3'd2;
  localparam logic [2:0] NS_DOCKED     = 3'd3;
  localparam logic [2:0] NS_GARDEN     = 3'd4;
  localparam logic [2:0] NS_PARKED     = 3'd5;

  localparam logic [1:0] ZONE_ONE = 2'd1;
  localparam logic [1:0] ZONE_TWO = 2'd2;

  typedef struct packed {
    logic [GAIN_W-1:0] p_gain;
    logic [15:0]       side_limit;
    logic [15:0]       side_short;
    logic              clockwise;
    logic [1:0]        zone_mode;
    logic [TIME_W-1:0] zone_one;
    logic [TIME_W-1:0] zone_two;
  } cfg_t;

  typedef struct packed {
    logic              action;
    logic              mag_neg;
    logic [PROD_W-1:0] prod;
    logic              is_inside;
    logic [ELAP_W-1:0] elapsed;
    logic              charging;
    logic              stop_key;
  } item_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [ELAP_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W + 1 - ELAP_W){1'b0}}, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

/* hdl/wfs_cfg.sv */
// Configuration register file of the wire follow steering controller.
module wfs_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output wfs_pkg::cfg_t     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.p_gain     <= 10'd100;
      cfg.side_limit <= 16'd10000;
      cfg.side_short <= 16'd2000;
      cfg.clockwise  <= 1'b1;
      cfg.zone_mode  <= 2'd0;
      cfg.zone_one   <= 32'd60000;
      cfg.zone_two   <= 32'd120000;
    end else if (cfg_we) begin
      case (cfg_index)
        wfs_pkg::REG_P_GAIN:     cfg.p_gain     <= cfg_data[wfs_pkg::GAIN_W-1:0];
        wfs_pkg::REG_SIDE_LIMIT: cfg.side_limit <= cfg_data[15:0];
        wfs_pkg::REG_SIDE_SHORT: cfg.side_short <= cfg_data[15:0];
        wfs_pkg::REG_CLOCKWISE:  cfg.clockwise  <= cfg_data[0];
        wfs_pkg::REG_ZONE_MODE:  cfg.zone_mode  <= cfg_data[1:0];
        wfs_pkg::REG_ZONE_ONE:   cfg.zone_one   <= cfg_data;
        wfs_pkg::REG_ZONE_TWO:   cfg.zone_two   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* hdl/wfs_in_stage.sv */
// Input register: captures a request and the gain product of its magnitude.
module wfs_in_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        action,
  input  logic signed [wfs_pkg::MAG_W-1:0] magnitude,
  input  logic                        inside_req,
  input  logic [wfs_pkg::ELAP_W-1:0]  elapsed_ms,
  input  logic                        charging,
  input  logic                        stop_key,
  input  logic [wfs_pkg::GAIN_W-1:0]  p_gain,
  input  logic                        take,
  output logic                        item_valid,
  output wfs_pkg::item_t              item
);

  logic [wfs_pkg::MAG_W-1:0]  mag_abs;
  logic [wfs_pkg::PROD_W-1:0] prod;

  assign in_ready = !item_valid || take;

  always_comb begin
    mag_abs = magnitude[wfs_pkg::MAG_W-1] ? (~magnitude + 1'b1) : magnitude;
    prod    = {{wfs_pkg::GAIN_W{1'b0}}, mag_abs} *
              {{wfs_pkg::MAG_W{1'b0}}, p_gain};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.action    <= action;
      item.mag_neg   <= magnitude[wfs_pkg::MAG_W-1];
      item.prod      <= prod;
      item.is_inside <= inside_req;
      item.elapsed   <= elapsed_ms;
      item.charging  <= charging;
      item.stop_key  <= stop_key;
    end
  end

endmodule

/* hdl/wfs_out_stage.sv */
// Side timers, steering, exit decision and the result register.
module wfs_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  wfs_pkg::cfg_t      cfg,
  input  logic               item_valid,
  input  wfs_pkg::item_t     item,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         left_speed,
  output logic [7:0]         right_speed,
  output logic [2:0]         drive_mode,
  output logic [2:0]         next_state
);

  logic [wfs_pkg::TIME_W-1:0] same_side_ms, same_side_ms_next;
  logic [wfs_pkg::TIME_W-1:0] since_entry_ms, since_entry_ms_next;
  logic                       last_side_inside, last_side_inside_next;
  logic [2:0]                 held_mode, held_mode_next;

  logic [wfs_pkg::PROD_W+wfs_pkg::RECIP_W-1:0] scaled;
  logic [wfs_pkg::CORR_W-1:0] corr;
  logic [wfs_pkg::CORR_W-1:0] corr_off;
  logic [7:0] wheel;
  logic       rot;
  logic [7:0] left_next, right_next;
  logic [2:0] mode_next, ns_next;
  logic       zone_hit;

  assign take = item_valid && (!out_valid || out_ready);

  always_comb begin
    scaled   = {{wfs_pkg::RECIP_W{1'b0}}, item.prod} *
               {{wfs_pkg::PROD_W{1'b0}}, wfs_pkg::RECIP_100};
    corr     = scaled[wfs_pkg::RECIP_SHIFT +: wfs_pkg::CORR_W];
    corr_off = corr - {8'd0, wfs_pkg::ROT_OFFSET};
    rot      = corr > {8'd0, wfs_pkg::SPEED_MAX};
    if (!rot) begin
      wheel = wfs_pkg::SPEED_MAX - corr[7:0];
    end else if (corr >= wfs_pkg::ROT_SAT) begin
      wheel = wfs_pkg::SPEED_MAX;
    end else begin
      wheel = corr_off[7:0];
    end
  end

  always_comb begin
    same_side_ms_next     = same_side_ms;
    since_entry_ms_next   = since_entry_ms;
    last_side_inside_next = last_side_inside;
    held_mode_next        = held_mode;
    left_next             = wfs_pkg::SPEED_MAX;
    right_next            = wfs_pkg::SPEED_MAX;
    mode_next             = wfs_pkg::MODE_FWD;
    ns_next               = wfs_pkg::NS_STAY;
    zone_hit              = 1'b0;
    if (!item.action) begin
      same_side_ms_next     = '0;
      since_entry_ms_next   = '0;
      last_side_inside_next = item.is_inside;
      held_mode_next        = wfs_pkg::MODE_FWD;
      left_next             = 8'd0;
      right_next            = 8'd0;
    end else begin
      since_entry_ms_next = wfs_pkg::sat_add(since_entry_ms, item.elapsed);
      if (item.charging) begin
        held_mode_next = wfs_pkg::MODE_STOP;
        left_next      = 8'd0;
        right_next     = 8'd0;
        mode_next      = wfs_pkg::MODE_STOP;
        ns_next        = wfs_pkg::NS_DOCKED;
      end else begin
        if (item.is_inside == last_side_inside) begin
          same_side_ms_next = wfs_pkg::sat_add(same_side_ms, item.elapsed);
          if (same_side_ms_next > {16'd0, cfg.side_short}) begin
            if (cfg.clockwise) begin
              held_mode_next = item.is_inside ? wfs_pkg::MODE_ONLY_RIGHT
                                              : wfs_pkg::MODE_ROT_LEFT;
            end else begin
              held_mode_next = item.is_inside ? wfs_pkg::MODE_ROT_LEFT
                                              : wfs_pkg::MODE_ONLY_RIGHT;
            end
          end
        end else begin
          last_side_inside_next = item.is_inside;
          same_side_ms_next     = '0;
        end
        if (cfg.clockwise) begin
          if (item.mag_neg) begin
            right_next     = wheel;
            held_mode_next = rot ? wfs_pkg::MODE_ROT_RIGHT : wfs_pkg::MODE_FWD;
          end else begin
            left_next      = wheel;
            held_mode_next = rot ? wfs_pkg::MODE_ROT_LEFT : wfs_pkg::MODE_FWD;
          end
        end
        zone_hit = (cfg.zone_mode == wfs_pkg::ZONE_ONE &&
                    since_entry_ms_next >= cfg.zone_one) ||
                   (cfg.zone_mode == wfs_pkg::ZONE_TWO &&
                    since_entry_ms_next >= cfg.zone_two);
        mode_next = held_mode_next;
        if (zone_hit) begin
          ns_next = wfs_pkg::NS_GARDEN;
        end else if (item.stop_key) begin
          ns_next = wfs_pkg::NS_PARKED;
        end
        // side timer exit overrides steering, zone and stop key
        if (item.is_inside == last_side_inside &&
            same_side_ms_next > {16'd0, cfg.side_limit}) begin
          left_next  = 8'd0;
          right_next = 8'd0;
          if (!item.is_inside) begin
            held_mode_next = wfs_pkg::MODE_STOP;
            mode_next      = wfs_pkg::MODE_STOP;
            ns_next        = wfs_pkg::NS_FIND_BACK;
          end else begin
            held_mode_next = wfs_pkg::MODE_BACK_SLOW;
            mode_next      = wfs_pkg::MODE_BACK_SLOW;
            ns_next        = wfs_pkg::NS_RANDOM_ROT;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      same_side_ms     <= '0;
      since_entry_ms   <= '0;
      last_side_inside <= 1'b0;
      held_mode        <= wfs_pkg::MODE_FWD;
      out_valid        <= 1'b0;
    end else begin
      if (take) begin
        same_side_ms     <= same_side_ms_next;
        since_entry_ms   <= since_entry_ms_next;
        last_side_inside <= last_side_inside_next;
        held_mode        <= held_mode_next;
        out_valid        <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      left_speed  <= left_next;
      right_speed <= right_next;
      drive_mode  <= mode_next;
      next_state  <= ns_next;
    end
  end

  a_enter_clears: assert property (@(posedge clk) disable iff (rst)
    take && !item.action |=> same_side_ms == '0 && since_entry_ms == '0)
    else $error("enter request left a timer running");

  a_charging_holds_side: assert property (@(posedge clk) disable iff (rst)
    take && item.action && item.charging |=>
      $stable(same_side_ms) && $stable(last_side_inside))
    else $error("charging request moved the side timer");

  a_docked_stops: assert property (@(posedge clk) disable iff (rst)
    out_valid && next_state == wfs_pkg::NS_DOCKED |->
      drive_mode == wfs_pkg::MODE_STOP && left_speed == 8'd0 && right_speed == 8'd0)
    else $error("docked result with wheels running");

endmodule

/* hdl/wire_follow_steering_controller.sv */
// Top level of the wire follow steering controller.
// Takes one control request per clock cycle unless out_ready stalls it, and returns one result
// per request: the input register loads at acceptance and the result register when the output
// stage takes the item, which out_ready can hold back; the side and entry timers are updated
// between the two registers. Configuration registers are written through cfg_we/cfg_index/
// cfg_data; the user must write them only while no request is in flight, which the block
// itself does not enforce. Indexes 0 to 6 are p_gain, same_side_limit_ms, same_side_short_ms,
// clockwise, zone_mode, zone_one_time_ms and zone_two_time_ms.
module wire_follow_steering_controller (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [2:0]                       cfg_index,
  input  logic [31:0]                      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             action,
  input  logic signed [wfs_pkg::MAG_W-1:0] magnitude,
  input  logic                             inside_req,
  input  logic [wfs_pkg::ELAP_W-1:0]       elapsed_ms,
  input  logic                             charging,
  input  logic                             stop_key,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       left_speed,
  output logic [7:0]                       right_speed,
  output logic [2:0]                       drive_mode,
  output logic [2:0]                       next_state
);

  wfs_pkg::cfg_t  cfg;
  wfs_pkg::item_t item;
  logic           item_valid;
  logic           take;

  wfs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wfs_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .magnitude  (magnitude),
    .inside_req (inside_req),
    .elapsed_ms (elapsed_ms),
    .charging   (charging),
    .stop_key   (stop_key),
    .p_gain     (cfg.p_gain),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  wfs_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_valid  (item_valid),
    .item        (item),
    .take        (take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .left_speed  (left_speed),
    .right_speed (right_speed),
    .drive_mode  (drive_mode),
    .next_state  (next_state)
  );

endmodule
